@@ sv/bfha_pkg.sv @@
// Shared constants, command and status types for the best-fit heap allocator.
// Used by the controller, the datapath and the port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bfha_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 16;
   localparam int UNIT_BYTES   = 16;
   localparam int UNIT_COUNT   = HEAP_BYTES / UNIT_BYTES;
   localparam int UNIT_W       = $clog2(UNIT_COUNT);
   localparam int LEN_W        = UNIT_W + 1;
   localparam int REQ_W        = 32;
   localparam int ADDR_W       = 16;
   localparam int NEED_W       = REQ_W + 1 - 4;
   localparam int BYTE_W       = (LEN_W + 5 > ADDR_W) ? LEN_W + 5 : ADDR_W + 1;
   // slack above this many units is split off as a new free segment
   localparam int SPLIT_MIN    = 2 * HEADER_BYTES / UNIT_BYTES;
   localparam int HDR_LOW      = HEADER_BYTES % UNIT_BYTES;

   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [UNIT_W-1:0] unit_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_START,
      OP_WALK,
      OP_PREV,
      OP_NEXT_RD,
      OP_NEXT,
      OP_SPLIT,
      OP_MARK
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic action_free;
      logic hit;
      logic hit_busy;
      logic seg_zero;
      logic walk_end;
      logic found;
      logic split;
      logic next_in;
   } status_type;

endpackage

`default_nettype wire

@@ sv/bfha_dpath.sv @@
// Datapath: segment tables, walk registers, split and merge arithmetic, result word.
// Depends on bfha_pkg; driven by commands from bfha_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bfha_dpath (
   input  logic                          clock,
   input  bfha_pkg::cmd_type             cmd,
   output bfha_pkg::status_type          status,
   input  logic                          req_action,
   input  logic [bfha_pkg::REQ_W-1:0]    req_request_bytes,
   input  logic [bfha_pkg::ADDR_W-1:0]   req_block_address,
   output logic                          rsp_granted,
   output logic [bfha_pkg::ADDR_W-1:0]   rsp_user_address
);
   import bfha_pkg::*;

   len_type  len_mem    [UNIT_COUNT];
   logic     busy_mem   [UNIT_COUNT];
   unit_type before_mem [UNIT_COUNT];

   len_type  rd_len_ff;
   logic     rd_busy_ff;
   unit_type rd_before_ff;
   unit_type rd_addr;

   logic     len_we, busy_we, before_we, busy_wd;
   unit_type len_wa, busy_wa, before_wa, before_wd;
   len_type  len_wd;

   logic              action_ff, need_ok_ff, found_ff, granted_ff;
   len_type           need_ff, pos_ff, best_slack_ff, best_len_ff, cur_len_ff;
   logic [ADDR_W-1:0] addr_ff, user_ff;
   unit_type          best_ff, seg_ff, prev_ff, next_ff;

   logic [REQ_W:0]    need_sum;
   logic [NEED_W-1:0] need_wide;
   logic              need_ok;
   logic [LEN_W:0]    pos_sum, next_sum, beyond_sum, after_sum, cut_sum;
   len_type           slack, merged, grown;
   logic              fits, better, hit, split;
   logic [BYTE_W-1:0] pos_bytes, best_bytes;

   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_wa] <= len_wd;
      if (busy_we) busy_mem[busy_wa] <= busy_wd;
      if (before_we) before_mem[before_wa] <= before_wd;
      rd_len_ff    <= len_mem[rd_addr];
      rd_busy_ff   <= busy_mem[rd_addr];
      rd_before_ff <= before_mem[rd_addr];
   end

   always_comb begin
      need_sum   = {1'b0, req_request_bytes} + (REQ_W+1)'(HEADER_BYTES + UNIT_BYTES - 1);
      need_wide  = need_sum[REQ_W:4];
      need_ok    = need_wide <= NEED_W'(UNIT_COUNT);
      pos_sum    = {1'b0, pos_ff} + {1'b0, rd_len_ff};
      slack      = rd_len_ff - need_ff;
      fits       = !rd_busy_ff && need_ok_ff && (rd_len_ff >= need_ff);
      better     = fits && (!found_ff || slack < best_slack_ff);
      pos_bytes  = (BYTE_W'(pos_ff) << 4) + BYTE_W'(HEADER_BYTES);
      hit        = action_ff && (pos_bytes == BYTE_W'(addr_ff));
      next_sum   = (LEN_W+1)'(seg_ff) + (LEN_W+1)'(cur_len_ff);
      beyond_sum = (LEN_W+1)'(next_ff) + (LEN_W+1)'(rd_len_ff);
      merged     = rd_len_ff + cur_len_ff;
      grown      = cur_len_ff + rd_len_ff;
      split      = best_slack_ff > LEN_W'(SPLIT_MIN);
      cut_sum    = (LEN_W+1)'(best_ff) + (LEN_W+1)'(need_ff);
      after_sum  = (LEN_W+1)'(best_ff) + (LEN_W+1)'(best_len_ff);
      best_bytes = (BYTE_W'(best_ff) << 4) + BYTE_W'(HEADER_BYTES);

      status.action_free = action_ff;
      status.hit         = hit;
      status.hit_busy    = rd_busy_ff;
      status.seg_zero    = pos_ff == '0;
      status.walk_end    = pos_sum >= (LEN_W+1)'(UNIT_COUNT);
      status.found       = found_ff;
      status.split       = split;
      status.next_in     = next_sum < (LEN_W+1)'(UNIT_COUNT);
   end

   always_comb begin
      rd_addr   = '0;
      len_we    = 1'b0;
      len_wa    = '0;
      len_wd    = '0;
      busy_we   = 1'b0;
      busy_wa   = '0;
      busy_wd   = 1'b0;
      before_we = 1'b0;
      before_wa = '0;
      before_wd = '0;
      case (cmd.op)
         OP_INIT: begin
            len_we  = 1'b1;
            len_wd  = LEN_W'(UNIT_COUNT);
            busy_we = 1'b1;
         end
         OP_WALK: begin
            rd_addr = pos_sum[UNIT_W-1:0];
            if (hit && rd_busy_ff) begin
               // release the block and fetch its previous neighbour
               busy_we = 1'b1;
               busy_wa = pos_ff[UNIT_W-1:0];
               rd_addr = rd_before_ff;
            end
         end
         OP_PREV: begin
            if (!rd_busy_ff) begin
               len_we = 1'b1;
               len_wa = prev_ff;
               len_wd = merged;
               if (status.next_in) begin
                  before_we = 1'b1;
                  before_wa = next_sum[UNIT_W-1:0];
                  before_wd = prev_ff;
               end
            end
         end
         OP_NEXT_RD: rd_addr = next_sum[UNIT_W-1:0];
         OP_NEXT: begin
            if (!rd_busy_ff) begin
               len_we = 1'b1;
               len_wa = seg_ff;
               len_wd = grown;
               if (beyond_sum < (LEN_W+1)'(UNIT_COUNT)) begin
                  before_we = 1'b1;
                  before_wa = beyond_sum[UNIT_W-1:0];
                  before_wd = seg_ff;
               end
            end
         end
         OP_SPLIT: begin
            len_we    = 1'b1;
            len_wa    = cut_sum[UNIT_W-1:0];
            len_wd    = best_slack_ff;
            busy_we   = 1'b1;
            busy_wa   = cut_sum[UNIT_W-1:0];
            before_we = 1'b1;
            before_wa = cut_sum[UNIT_W-1:0];
            before_wd = best_ff;
         end
         OP_MARK: begin
            busy_we = 1'b1;
            busy_wa = best_ff;
            busy_wd = 1'b1;
            if (split) begin
               len_we = 1'b1;
               len_wa = best_ff;
               len_wd = need_ff;
               if (after_sum < (LEN_W+1)'(UNIT_COUNT)) begin
                  before_we = 1'b1;
                  before_wa = after_sum[UNIT_W-1:0];
                  before_wd = cut_sum[UNIT_W-1:0];
               end
            end
         end
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            action_ff  <= req_action;
            need_ff    <= need_wide[LEN_W-1:0];
            need_ok_ff <= need_ok;
            addr_ff    <= req_block_address;
            pos_ff     <= '0;
            found_ff   <= 1'b0;
         end
         OP_WALK: begin
            pos_ff <= pos_sum[LEN_W-1:0];
            if (!action_ff && better) begin
               found_ff      <= 1'b1;
               best_ff       <= pos_ff[UNIT_W-1:0];
               best_slack_ff <= slack;
               best_len_ff   <= rd_len_ff;
            end
            if (hit) begin
               seg_ff     <= pos_ff[UNIT_W-1:0];
               cur_len_ff <= rd_len_ff;
               prev_ff    <= rd_before_ff;
            end
         end
         OP_PREV: begin
            if (!rd_busy_ff) begin
               seg_ff     <= prev_ff;
               cur_len_ff <= merged;
            end
         end
         OP_NEXT_RD: next_ff <= next_sum[UNIT_W-1:0];
         default: next_ff <= next_ff;
      endcase
      if (cmd.load_rsp) begin
         granted_ff <= !action_ff && found_ff;
         user_ff    <= (!action_ff && found_ff) ? best_bytes[ADDR_W-1:0] : '0;
      end
   end

   assign rsp_granted      = granted_ff;
   assign rsp_user_address = user_ff;

endmodule

`default_nettype wire

@@ sv/bfha_ctrl.sv @@
// Controller: sequences table set-up, the segment walk, split and merge steps and
// the result handshake. Depends on bfha_pkg; commands bfha_dpath.
`timescale 1ns / 1ps
`default_nettype none

module bfha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bfha_pkg::status_type status,
   output bfha_pkg::cmd_type    cmd
);
   import bfha_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_WALK, S_DECIDE, S_SPLIT, S_MARK,
      S_PREV, S_NEXT_RD, S_NEXT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in, valid_ff, valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_START;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.op = OP_WALK;
            if (status.hit) begin
               if (!status.hit_busy) state_in = S_DONE;
               else if (status.seg_zero) state_in = S_NEXT_RD;
               else state_in = S_PREV;
            end else if (status.walk_end) begin
               state_in = status.action_free ? S_DONE : S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!status.found) state_in = S_DONE;
            else if (status.split) state_in = S_SPLIT;
            else state_in = S_MARK;
         end
         S_SPLIT: begin
            cmd.op   = OP_SPLIT;
            state_in = S_MARK;
         end
         S_MARK: begin
            cmd.op   = OP_MARK;
            state_in = S_DONE;
         end
         S_PREV: begin
            cmd.op   = OP_PREV;
            state_in = S_NEXT_RD;
         end
         S_NEXT_RD: begin
            cmd.op   = OP_NEXT_RD;
            state_in = status.next_in ? S_NEXT : S_DONE;
         end
         S_NEXT: begin
            cmd.op   = OP_NEXT;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
      stall_in = state_in != S_IDLE;
      if (cmd.load_rsp) valid_in = 1'b1;
      else if (!rsp_stall) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         stall_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = stall_ff;
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

@@ sv/best_fit_heap_allocator_unit.sv @@
// Top level of the best-fit heap allocator: controller plus datapath.
// Depends on bfha_pkg, bfha_ctrl and bfha_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Best-fit allocator over a 64 KiB heap kept as address-ordered segments of
// 16-byte units, each opening with a 16-byte header. One word is taken at a
// time. After reset the block sets up the segment table before it takes a word.
// An allocate word walks every segment, one table read per cycle; a free word
// stops at its segment and then merges with its free neighbours. The walk runs
// over the single read port of the segment table. A result answers every word:
// granted with the user offset, or zero for failures and frees.
module best_fit_heap_allocator_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [bfha_pkg::REQ_W-1:0]   req_request_bytes,
   input  logic [bfha_pkg::ADDR_W-1:0]  req_block_address,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_granted,
   output logic [bfha_pkg::ADDR_W-1:0]  rsp_user_address
);
   import bfha_pkg::*;

   cmd_type    cmd;
   status_type status;

   bfha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bfha_dpath u_dpath (
      .clock             (clock),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_request_bytes (req_request_bytes),
      .req_block_address (req_block_address),
      .rsp_granted       (rsp_granted),
      .rsp_user_address  (rsp_user_address)
   );

endmodule

`default_nettype wire

@@ sv/bfha_checker.sv @@
// Port-level checks for best_fit_heap_allocator_unit, bound to the top level.
// Depends on bfha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfha_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_granted,
   input logic [bfha_pkg::ADDR_W-1:0]  rsp_user_address
);
   import bfha_pkg::*;

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_user_address == '0)
      else $error("refused word carries an address");

   a_grant_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_user_address[3:0] == 4'(HDR_LOW))
      else $error("granted address off the unit grid");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while the first is in work");

   a_stall_in_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open straight after reset");

endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_granted      (rsp_granted),
   .rsp_user_address (rsp_user_address)
);

`default_nettype wire
